@@ rtl/core/sas_pkg.sv @@
// Shared types, constants and helpers for the sprite animation sequencer.
// No dependencies; imported by every module of the block.
package sas_pkg;

  localparam int MAX_SUBSEQS = 8;
  localparam int MAX_FRAMES  = 16;
  localparam int TIME_BITS   = 16;

  localparam int SUBSEQ_W     = $clog2(MAX_SUBSEQS);  // subsequence index
  localparam int FRAME_W      = $clog2(MAX_FRAMES);   // frame index
  localparam int FCNT_W       = FRAME_W + 1;          // frame count, 1..MAX_FRAMES
  localparam int SCNT_W       = 4;                    // subseq_count register
  localparam int NUM_W        = 8;                    // subseq/frame number fields
  localparam int FADDR_W      = SUBSEQ_W + FRAME_W;
  localparam int FRAME_SLOTS  = MAX_SUBSEQS * MAX_FRAMES;
  localparam int FENTRY_W     = TIME_BITS + 1;        // duration + image bit
  localparam int SENTRY_W     = FCNT_W + 1;           // frame count + looped bit

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_RESTART     = 3'd1,
    OP_SET_FRAME   = 3'd2,
    OP_SET_SUBSEQ  = 3'd3,
    OP_SET_ELAPSED = 3'd4,
    OP_WR_FRAME    = 3'd5,
    OP_WR_SUBSEQ   = 3'd6
  } op_e;

  // Request to / response from the small modulo unit.
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [SCNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [SUBSEQ_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [TIME_BITS-1:0] sat_inc(logic [TIME_BITS-1:0] v);
    return (v == TIME_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [FCNT_W-1:0] clamp_fcnt(logic [FCNT_W-1:0] c);
    logic [FCNT_W-1:0] r;
    r = c;
    if (c == '0) r = FCNT_W'(1);
    else if (c > FCNT_W'(MAX_FRAMES)) r = FCNT_W'(MAX_FRAMES);
    return r;
  endfunction

  function automatic logic [SCNT_W-1:0] clamp_scnt(logic [SCNT_W-1:0] c);
    logic [SCNT_W-1:0] r;
    r = c;
    if (c == '0) r = SCNT_W'(1);
    else if (c > SCNT_W'(MAX_SUBSEQS)) r = SCNT_W'(MAX_SUBSEQS);
    return r;
  endfunction

endpackage

@@ rtl/core/sas_mod.sv @@
// Bit-serial restoring modulo: 8-bit dividend by a 1..8 divisor.
// One quotient bit per cycle; depends on sas_pkg.
module sas_mod
  import sas_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(NUM_W);

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   step_q;
  logic [NUM_W-1:0]    dvd_q;
  logic [SCNT_W-1:0]   dsr_q;
  logic [SUBSEQ_W-1:0] rem_q, rem_d;
  logic [SUBSEQ_W:0]   trial;

  // remainder stays below the divisor, so one extra bit covers the trial
  assign trial = {rem_q, dvd_q[NUM_W-1]};

  always_comb begin
    if ({1'b0, trial} >= {1'b0, dsr_q}) begin
      rem_d = SUBSEQ_W'(trial - dsr_q);
    end else begin
      rem_d = trial[SUBSEQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/core/sprite_animation_sequencer.sv @@
// Top level of the sprite animation sequencer: control FSM, frame and
// subsequence table memories, playback state. Depends on sas_pkg, sas_mod.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per operation:
//   tick, restart, set frame, set subsequence, set elapsed, write frame
//   entry, write subsequence entry. Every item yields exactly one result item
//   on the output channel (out_valid_o / out_stall_i) holding the playback
//   state after the operation, plus the done / ignored flags.
//   One item is processed at a time. After the accepting edge the item
//   passes the execute state and then, by operation:
//     tick without frame advance, set elapsed, table writes, unused code,
//       set frame out of range: straight to the result
//     tick with frame advance, set frame, restart: a table read first
//     set subsequence: the bit-serial modulo, then a table read
//     tick that moves to another subsequence: a table read, the modulo,
//       then a second table read. Table memory reads are registered.
//   The next item is taken the cycle after the result is loaded. The
//   result sits in an output register and the next item is taken while it
//   still waits; if the receiver stalls, the block holds the new result in
//   its final state until the output register frees.
//   Write subseq_count (cfg_we_i/cfg_wdata_i) only while idle; not enforced.
//   Reset: playback at subsequence 0, frame 0, frame count 1, counters and
//   duration 0, subseq_count 1. Table memories are not cleared; entries must
//   be written before they are played.
module sprite_animation_sequencer
  import sas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [SCNT_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           operation_i,
  input  logic                 ignore_loop_i,
  input  logic [NUM_W-1:0]     subseq_number_i,
  input  logic [NUM_W-1:0]     frame_number_i,
  input  logic [TIME_BITS-1:0] elapsed_value_i,
  input  logic [TIME_BITS-1:0] entry_duration_i,
  input  logic                 entry_has_image_i,
  input  logic [FCNT_W-1:0]    entry_frame_count_i,
  input  logic                 entry_looped_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FRAME_W-1:0]   frame_index_o,
  output logic [SUBSEQ_W-1:0]  subseq_index_o,
  output logic [TIME_BITS-1:0] frame_time_o,
  output logic [TIME_BITS-1:0] elapsed_frames_o,
  output logic                 sequence_done_o,
  output logic                 request_ignored_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK_LD,
    S_MOD,
    S_FRAME_LD,
    S_ENTER_LD,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [SCNT_W-1:0] subseq_count_q;

  // captured item
  op_e                  op_q;
  logic                 ign_q;
  logic [NUM_W-1:0]     sn_q, fn_q;
  logic [TIME_BITS-1:0] ev_q, ed_q;
  logic                 ei_q, el_q;
  logic [FCNT_W-1:0]    ec_q;

  // playback state
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic [SUBSEQ_W-1:0]  subseq_q, subseq_d;
  logic [FCNT_W-1:0]    fcnt_q, fcnt_d;
  logic [TIME_BITS-1:0] timer_q, timer_d;
  logic [TIME_BITS-1:0] dur_q, dur_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic                 done_q, done_d;
  logic                 ignored_q, ignored_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [FRAME_W-1:0]   out_frame_q;
  logic [SUBSEQ_W-1:0]  out_subseq_q;
  logic [TIME_BITS-1:0] out_timer_q, out_elapsed_q;
  logic                 out_done_q, out_ignored_q;

  // table memories
  logic [FENTRY_W-1:0]  fmem [FRAME_SLOTS];
  logic [SENTRY_W-1:0]  smem [MAX_SUBSEQS];
  logic                 fmem_we, fmem_re, smem_we, smem_re;
  logic [FADDR_W-1:0]   fmem_addr;
  logic [SUBSEQ_W-1:0]  smem_addr;
  logic [FENTRY_W-1:0]  fmem_rdata_q;
  logic [SENTRY_W-1:0]  smem_rdata_q;

  // modulo unit
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic                 accept;
  logic [TIME_BITS-1:0] timer_inc;
  logic [FCNT_W-1:0]    frame_nxt;
  logic [FRAME_W-1:0]   frame_wrap;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign timer_inc  = sat_inc(timer_q);
  // frame stays below the frame count, so wrap is a single compare
  assign frame_nxt  = {1'b0, frame_q} + 1'b1;
  assign frame_wrap = (frame_nxt >= fcnt_q) ? '0 : frame_nxt[FRAME_W-1:0];

  sas_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    subseq_d    = subseq_q;
    fcnt_d      = fcnt_q;
    timer_d     = timer_q;
    dur_d       = dur_q;
    elapsed_d   = elapsed_q;
    done_d      = done_q;
    ignored_d   = ignored_q;
    out_load    = 1'b0;

    fmem_we     = 1'b0;
    fmem_re     = 1'b0;
    fmem_addr   = {sn_q[SUBSEQ_W-1:0], fn_q[FRAME_W-1:0]};
    smem_we     = 1'b0;
    smem_re     = 1'b0;
    smem_addr   = sn_q[SUBSEQ_W-1:0];

    mod_req.start    = 1'b0;
    mod_req.dividend = sn_q;
    mod_req.divisor  = clamp_scnt(subseq_count_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d    = 1'b0;
          ignored_d = 1'b0;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_TICK: begin
            elapsed_d = sat_inc(elapsed_q);
            timer_d   = timer_inc;
            if (timer_inc >= dur_q) begin
              frame_d   = frame_wrap;
              fmem_re   = 1'b1;
              fmem_addr = {subseq_q, frame_wrap};
              smem_re   = 1'b1;
              smem_addr = subseq_q;
              state_d   = S_TICK_LD;
            end
          end
          OP_RESTART: begin
            subseq_d  = '0;
            elapsed_d = '0;
            frame_d   = '0;
            fmem_re   = 1'b1;
            fmem_addr = '0;
            smem_re   = 1'b1;
            smem_addr = '0;
            state_d   = S_ENTER_LD;
          end
          OP_SET_FRAME: begin
            if ({1'b0, fn_q} >= {(NUM_W + 1 - FCNT_W)'(0), fcnt_q}) begin
              ignored_d = 1'b1;
            end else begin
              frame_d   = fn_q[FRAME_W-1:0];
              fmem_re   = 1'b1;
              fmem_addr = {subseq_q, fn_q[FRAME_W-1:0]};
              state_d   = S_FRAME_LD;
            end
          end
          OP_SET_SUBSEQ: begin
            mod_req.start = 1'b1;
            state_d       = S_MOD;
          end
          OP_SET_ELAPSED: begin
            elapsed_d = ev_q;
          end
          OP_WR_FRAME: begin
            fmem_we = (sn_q < NUM_W'(MAX_SUBSEQS)) && (fn_q < NUM_W'(MAX_FRAMES));
          end
          OP_WR_SUBSEQ: begin
            smem_we = (sn_q < NUM_W'(MAX_SUBSEQS));
          end
          default: ;
        endcase
      end

      // frame entry of the advanced frame, loop flag of the current subsequence
      S_TICK_LD: begin
        if (fmem_rdata_q[0]) begin
          timer_d = '0;
          dur_d   = fmem_rdata_q[FENTRY_W-1:1];
        end
        state_d = S_DONE;
        if (frame_q == '0 && (!smem_rdata_q[0] || ign_q)) begin
          mod_req.start    = 1'b1;
          mod_req.dividend = NUM_W'(subseq_q) + 1'b1;
          state_d          = S_MOD;
        end
      end

      // enter subsequence (mod result) at frame 0
      S_MOD: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem != subseq_q) elapsed_d = '0;
          if (mod_rsp.rem == '0) begin
            elapsed_d = '0;
            done_d    = 1'b1;
          end
          subseq_d  = mod_rsp.rem;
          frame_d   = '0;
          fmem_re   = 1'b1;
          fmem_addr = {mod_rsp.rem, FRAME_W'(0)};
          smem_re   = 1'b1;
          smem_addr = mod_rsp.rem;
          state_d   = S_ENTER_LD;
        end
      end

      S_FRAME_LD: begin
        if (fmem_rdata_q[0]) begin
          timer_d = '0;
          dur_d   = fmem_rdata_q[FENTRY_W-1:1];
        end
        state_d = S_DONE;
      end

      S_ENTER_LD: begin
        fcnt_d = clamp_fcnt(smem_rdata_q[SENTRY_W-1:1]);
        if (fmem_rdata_q[0]) begin
          timer_d = '0;
          dur_d   = fmem_rdata_q[FENTRY_W-1:1];
        end
        state_d = S_DONE;
      end

      // wait for a free output register
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      subseq_count_q <= SCNT_W'(1);
      frame_q        <= '0;
      subseq_q       <= '0;
      fcnt_q         <= FCNT_W'(1);
      timer_q        <= '0;
      dur_q          <= '0;
      elapsed_q      <= '0;
      done_q         <= 1'b0;
      ignored_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) subseq_count_q <= cfg_wdata_i;
      frame_q     <= frame_d;
      subseq_q    <= subseq_d;
      fcnt_q      <= fcnt_d;
      timer_q     <= timer_d;
      dur_q       <= dur_d;
      elapsed_q   <= elapsed_d;
      done_q      <= done_d;
      ignored_q   <= ignored_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      ign_q <= ignore_loop_i;
      sn_q  <= subseq_number_i;
      fn_q  <= frame_number_i;
      ev_q  <= elapsed_value_i;
      ed_q  <= entry_duration_i;
      ei_q  <= entry_has_image_i;
      ec_q  <= entry_frame_count_i;
      el_q  <= entry_looped_i;
    end
    if (out_load) begin
      out_frame_q   <= frame_q;
      out_subseq_q  <= subseq_q;
      out_timer_q   <= timer_q;
      out_elapsed_q <= elapsed_q;
      out_done_q    <= done_q;
      out_ignored_q <= ignored_q;
    end
  end

  // table memories, registered read
  always_ff @(posedge clk_i) begin
    if (fmem_we) fmem[fmem_addr] <= {ed_q, ei_q};
    if (fmem_re) fmem_rdata_q <= fmem[fmem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) smem[smem_addr] <= {ec_q, el_q};
    if (smem_re) smem_rdata_q <= smem[smem_addr];
  end

  assign out_valid_o       = out_valid_q;
  assign frame_index_o     = out_frame_q;
  assign subseq_index_o    = out_subseq_q;
  assign frame_time_o      = out_timer_q;
  assign elapsed_frames_o  = out_elapsed_q;
  assign sequence_done_o   = out_done_q;
  assign request_ignored_o = out_ignored_q;

endmodule

@@ rtl/core/sas_checker.sv @@
// Port-level assertions for the sprite animation sequencer, bound to the
// top level. Depends on sas_pkg for the field widths.
module sas_checker
  import sas_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [FRAME_W-1:0]   frame_index_o,
  input logic [SUBSEQ_W-1:0]  subseq_index_o,
  input logic [TIME_BITS-1:0] frame_time_o,
  input logic [TIME_BITS-1:0] elapsed_frames_o,
  input logic                 sequence_done_o,
  input logic                 request_ignored_o
);

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a second item back to back");

  // landing on subsequence 0 resets frame and elapsed count
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sequence_done_o |->
      subseq_index_o == '0 && frame_index_o == '0 && elapsed_frames_o == '0)
    else $error("sequence_done with non-initial position");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_ignored_o |-> !sequence_done_o)
    else $error("ignored and done in the same result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(frame_index_o) && $stable(subseq_index_o) &&
      $stable(frame_time_o) && $stable(elapsed_frames_o))
    else $error("stalled result changed");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (.*);
